FILE: design/sprng_pkg.sv
// Shared constants and channel payload types of the SHA-1 pool generator.
package sprng_pkg;

  // Default sizing
  localparam int unsigned PoolBytesDefault = 1023;
  localparam int unsigned MaxReadDefault   = 64;

  // Fixed algorithm constants
  localparam logic [7:0]  EntropyNeededReset = 8'd32;
  localparam logic [7:0]  DotByte            = 8'h2E;
  localparam logic [12:0] EstMax             = 13'd8191;

  // Operation codes
  typedef enum logic [2:0] {
    OP_RESET  = 3'd0,
    OP_ADD    = 3'd1,
    OP_SEED   = 3'd2,
    OP_READ   = 3'd3,
    OP_STATUS = 3'd4
  } op_e;

  // Input item
  typedef struct packed {
    logic [2:0]  operation;
    logic [7:0]  data_byte;
    logic        last;
    logic [11:0] entropy_credit;
    logic [6:0]  read_count;
  } in_item_t;

  // Result item
  typedef struct packed {
    logic [7:0] random_byte;
    logic       last_byte;
    logic       seeded;
  } out_item_t;

endpackage

FILE: design/sprng_chan_if.sv
// Valid/ready channel carrying one payload item per transfer.
interface sprng_chan_if #(parameter type T = logic);
  logic valid;
  logic ready;
  T     data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

FILE: design/sha1_pool_deterministic_prng_top.sv
// SHA-1 pool random generator: sequencer, pool memory and shared SHA-1 core.
//
// Items are taken one at a time; in_i.ready is high only while the block is idle.
// After reset, and for every reset-pool item, a clearing pass writes the
// POOL_BYTES+20 pool bytes, one per cycle, before any item is taken; a reset-pool
// item then mixes ceil(POOL_BYTES/20) chunks of dots. An add or seed byte that does
// not complete a chunk is stored in the chunk buffer. A chunk runs a restoring
// remainder for the new pool index, then per message block (one or two) assembles
// it from the pool memory and runs the 80 rounds and the final add, then folds a
// j-byte digest back into the pool. A read of n bytes runs ceil(n/10) groups and a
// closing hash; a status item returns a single result. The work is paced by the
// one-round-per-cycle SHA-1 core and the single pool memory, which moves one byte
// per cycle when assembling and reads each byte, then writes it back, when updated.
// Results wait in an output register.
module sha1_pool_deterministic_prng_top
  import sprng_pkg::*;
#(
  parameter int unsigned POOL_BYTES = PoolBytesDefault,
  parameter int unsigned MAX_READ   = MaxReadDefault
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         cfg_we_i,
  input  logic [7:0]   cfg_wdata_i,
  sprng_chan_if.sink   in_i,
  sprng_chan_if.source out_o
);

  localparam int unsigned TOTAL = POOL_BYTES + 20;
  localparam int unsigned AW    = $clog2(TOTAL);
  localparam int unsigned PIW   = $clog2(POOL_BYTES + 1);
  localparam int unsigned MAXC  = ((MAX_READ + 9) / 10) * 10;
  localparam int unsigned NW    = $clog2(POOL_BYTES + MAXC + 1);
  localparam int unsigned MBW   = $clog2(NW + 1);
  localparam int unsigned NDOTS = (POOL_BYTES + 19) / 20;
  localparam int unsigned DW    = $clog2(NDOTS + 1);

  localparam logic [AW:0]  POOL_W  = (AW+1)'(POOL_BYTES);
  localparam logic [AW:0]  TOTAL_W = (AW+1)'(TOTAL);
  localparam logic [PIW:0] POOL_P  = (PIW+1)'(POOL_BYTES);
  localparam logic [NW-1:0] POOL_N = NW'(POOL_BYTES);

  localparam logic [159:0] SHA_IV =
    160'h67452301_EFCDAB89_98BADCFE_10325476_C3D2E1F0;

  typedef enum logic [10:0] {
    S_CLEAR = 11'b000_0000_0001,
    S_IDLE  = 11'b000_0000_0010,
    S_STAT  = 11'b000_0000_0100,
    S_DOTS  = 11'b000_0000_1000,
    S_MOD   = 11'b000_0001_0000,
    S_LOAD  = 11'b000_0010_0000,
    S_ROUND = 11'b000_0100_0000,
    S_FIN   = 11'b000_1000_0000,
    S_XRD   = 11'b001_0000_0000,
    S_XWR   = 11'b010_0000_0000,
    S_POST  = 11'b100_0000_0000
  } state_e;

  typedef enum logic [1:0] {
    MK_CHUNK = 2'd0,
    MK_GROUP = 2'd1,
    MK_FINAL = 2'd2
  } msg_kind_e;

  // Byte i of a digest-ordered 160-bit value
  function automatic logic [7:0] dig_byte(logic [159:0] v, logic [4:0] i);
    return 8'(v >> (8 * (19 - int'(i))));
  endfunction

  // Little-endian byte k of a word
  function automatic logic [7:0] le_byte(logic [31:0] w, logic [1:0] k);
    return 8'(w >> (8 * int'(k)));
  endfunction

  // Request length rounded up to whole groups of ten
  function automatic logic [7:0] ceil_ten(logic [6:0] n);
    logic [2:0] grp;
    grp = '0;
    for (int k = 0; k < 7; k++) begin
      if (n > 7'(10 * k)) grp = grp + 3'd1;
    end
    return ({5'd0, grp} << 3) + ({5'd0, grp} << 1);
  endfunction

  state_e       state_q, state_d;
  msg_kind_e    kind_q, kind_d;
  logic [7:0]   needed_q, needed_d;
  logic [PIW-1:0] pidx_q, pidx_d, filled_q, filled_d, st_q, st_d, m_q, m_d, mden_q, mden_d;
  logic [12:0]  est_q, est_d, credit_q, credit_d;
  logic [31:0]  rc_q, rc_d, cc_q, cc_d;
  logic [159:0] cv_q, cv_d, lc_q, lc_d, lmd_q, lmd_d;
  logic [15:0]  clen_q, clen_d;
  logic [4:0]   fill_q, fill_d, j_q, j_d, t_q, t_d;
  logic [6:0]   left_q, left_d, lcnt_q, lcnt_d, rnd_q, rnd_d;
  logic         ok_q, ok_d, last_q, last_d, dots_q, dots_d, dpend_q, dpend_d;
  logic [DW-1:0] dcnt_q, dcnt_d;
  logic [NW-1:0] idx_q, idx_d, mnum_q, mnum_d;
  logic [PIW:0] rem_q, rem_d;
  logic [MBW-1:0] mbit_q, mbit_d;
  logic         blk_q, blk_d;
  logic         p_valid_q, p_valid_d, p_pool_q, p_pool_d;
  logic [5:0]   p_pos_q, p_pos_d;
  logic [7:0]   p_byte_q, p_byte_d;
  logic [31:0]  w_q [16];
  logic [31:0]  w_d [16];
  logic [31:0]  a_q, b_q, c_q, d_q, e_q, a_d, b_d, c_d, d_d, e_d;
  logic [159:0] h_q, h_d;
  logic [AW-1:0] wa_q, wa_d, clr_q, clr_d;
  logic         out_valid_q, out_valid_d;
  out_item_t    out_q, out_d;
  logic [7:0]   cbuf_q [20];
  logic         cbuf_we;

  // Pool memory port signals
  logic [7:0]   pool_mem [TOTAL];
  logic [7:0]   rd_q;
  logic         mem_we, mem_re;
  logic [AW-1:0] mem_wa, mem_ra;
  logic [7:0]   mem_wd;

  in_item_t     item;
  logic         in_fire, out_free, ok_now;

  assign item     = in_i.data;
  assign in_i.ready = (state_q == S_IDLE);
  assign in_fire  = in_i.valid && (state_q == S_IDLE);
  assign out_free = !out_valid_q || out_o.ready;
  assign ok_now   = est_q >= {1'b0, needed_q, 4'd0};
  assign out_o.valid = out_valid_q;
  assign out_o.data  = out_q;

  // Pool memory, one write and one registered read per cycle
  always_ff @(posedge clk_i) begin
    if (mem_we) pool_mem[mem_wa] <= mem_wd;
    if (mem_re) rd_q <= pool_mem[mem_ra];
  end

  // Chunk buffer, written at the fill position
  always_ff @(posedge clk_i) begin
    if (cbuf_we) cbuf_q[fill_q] <= item.data_byte;
  end

  // Message assembly stage: pick the byte at message position g
  logic [6:0]   g, mlen, e2, e3, e4, off;
  logic         last_blk, s0_pool;
  logic [7:0]   s0_byte;
  logic [AW:0]  psum;
  logic [AW-1:0] s0_addr;
  logic [9:0]   bitlen;

  always_comb begin
    g        = {blk_q, lcnt_q[5:0]};
    e2       = 7'd20 + 7'(j_q);
    e3       = e2 + 7'(j_q);
    e4       = e3 + 7'd4;
    case (kind_q)
      MK_CHUNK: mlen = e4 + 7'd4;
      MK_GROUP: mlen = 7'd38;
      default:  mlen = 7'd48;
    endcase
    last_blk = (mlen >= 7'd56);
    bitlen   = {mlen, 3'd0};
    s0_pool  = 1'b0;
    s0_byte  = 8'd0;
    off      = (kind_q == MK_CHUNK) ? g - 7'd20 : g - 7'd28;
    psum     = (AW+1)'(st_q) + (AW+1)'(off);
    if (kind_q == MK_CHUNK) begin
      if (psum >= POOL_W) psum = psum - POOL_W;
    end else if (psum >= (AW+1)'(m_q)) begin
      psum = psum - (AW+1)'(m_q);
    end
    if (psum >= TOTAL_W) psum = '0;
    s0_addr = psum[AW-1:0];
    if (g < mlen) begin
      case (kind_q)
        MK_CHUNK: begin
          if (g < 7'd20) s0_byte = dig_byte(lc_q, g[4:0]);
          else if (g < e2) s0_pool = 1'b1;
          else if (g < e3) s0_byte = dots_q ? DotByte : cbuf_q[5'(g - e2)];
          else if (g < e4) s0_byte = le_byte(rc_q, 2'(g - e3));
          else s0_byte = le_byte(cc_q, 2'(g - e4));
        end
        MK_GROUP: begin
          if (g < 7'd20) s0_byte = dig_byte(lmd_q, g[4:0]);
          else if (g < 7'd24) s0_byte = le_byte(rc_q, g[1:0]);
          else if (g < 7'd28) s0_byte = le_byte(cc_q, g[1:0]);
          else s0_pool = 1'b1;
        end
        default: begin
          if (g < 7'd4) s0_byte = le_byte(rc_q, g[1:0]);
          else if (g < 7'd8) s0_byte = le_byte(cc_q, g[1:0]);
          else if (g < 7'd28) s0_byte = dig_byte(lmd_q, 5'(g - 7'd8));
          else s0_byte = dig_byte(cv_q, 5'(g - 7'd28));
        end
      endcase
    end else if (g == mlen) begin
      s0_byte = 8'h80;
    end else if (blk_q == last_blk && lcnt_q[5:0] == 6'd63) begin
      s0_byte = bitlen[7:0];
    end else if (blk_q == last_blk && lcnt_q[5:0] == 6'd62) begin
      s0_byte = {6'd0, bitlen[9:8]};
    end
  end

  // SHA-1 round logic
  logic [31:0] f, k, tmp, wnew;
  logic [159:0] dig;
  always_comb begin
    if (rnd_q < 7'd20) begin
      f = (b_q & c_q) | (~b_q & d_q); k = 32'h5A827999;
    end else if (rnd_q < 7'd40) begin
      f = b_q ^ c_q ^ d_q; k = 32'h6ED9EBA1;
    end else if (rnd_q < 7'd60) begin
      f = (b_q & c_q) | (b_q & d_q) | (c_q & d_q); k = 32'h8F1BBCDC;
    end else begin
      f = b_q ^ c_q ^ d_q; k = 32'hCA62C1D6;
    end
    tmp  = {a_q[26:0], a_q[31:27]} + f + e_q + k + w_q[0];
    wnew = w_q[13] ^ w_q[8] ^ w_q[2] ^ w_q[0];
    wnew = {wnew[30:0], wnew[31]};
    dig  = {h_q[159:128] + a_q, h_q[127:96] + b_q, h_q[95:64] + c_q,
            h_q[63:32] + d_q, h_q[31:0] + e_q};
  end

  // Sequencer
  logic [15:0]  cl_inc;
  logic [4:0]   fill_inc;
  logic [6:0]   numc;
  logic [7:0]   c10;
  logic [10:0]  num16;
  logic [PIW:0] rem_sh;
  logic [3:0]   jg;
  logic [7:0]   xbyte;
  logic [AW:0]  st_nx;
  logic [PIW-1:0] lim;
  logic [13:0]  est_sum;
  logic         xdone;

  always_comb begin
    state_d = state_q;   kind_d = kind_q;     needed_d = needed_q;
    pidx_d = pidx_q;     filled_d = filled_q; st_d = st_q;  m_d = m_q;
    mden_d = mden_q;     est_d = est_q;       credit_d = credit_q;
    rc_d = rc_q;         cc_d = cc_q;         cv_d = cv_q;  lc_d = lc_q;
    lmd_d = lmd_q;       clen_d = clen_q;     fill_d = fill_q;
    j_d = j_q;           t_d = t_q;           left_d = left_q;
    lcnt_d = lcnt_q;     rnd_d = rnd_q;       ok_d = ok_q;  last_d = last_q;
    dots_d = dots_q;     dpend_d = dpend_q;   dcnt_d = dcnt_q;
    idx_d = idx_q;       mnum_d = mnum_q;     rem_d = rem_q; mbit_d = mbit_q;
    blk_d = blk_q;       h_d = h_q;           wa_d = wa_q;  clr_d = clr_q;
    a_d = a_q; b_d = b_q; c_d = c_q; d_d = d_q; e_d = e_q;
    w_d = w_q;
    p_valid_d = 1'b0;    p_pool_d = s0_pool;  p_pos_d = lcnt_q[5:0]; p_byte_d = s0_byte;
    out_valid_d = out_valid_q && !out_o.ready;
    out_d = out_q;
    cbuf_we = 1'b0;
    mem_we = 1'b0; mem_wa = wa_q; mem_wd = '0;
    mem_re = 1'b0; mem_ra = s0_addr;

    cl_inc   = (clen_q == 16'hFFFF) ? clen_q : clen_q + 16'd1;
    fill_inc = fill_q + 5'd1;
    numc     = (item.read_count > 7'(MAX_READ)) ? 7'(MAX_READ) : item.read_count;
    c10      = ceil_ten(numc);
    num16    = {numc, 4'd0};
    rem_sh   = {rem_q[PIW-1:0], mnum_q[NW-1]};
    jg       = (left_q >= 7'd10) ? 4'd10 : left_q[3:0];
    xbyte    = dig_byte((kind_q == MK_CHUNK) ? lc_q : lmd_q, t_q);
    lim      = (kind_q == MK_CHUNK) ? PIW'(POOL_BYTES) : m_q;
    st_nx    = (AW+1)'(wa_q) + 1'b1;
    est_sum  = {1'b0, est_q} + {1'b0, credit_q};
    xdone    = (kind_q == MK_CHUNK) ? (t_q == j_q - 5'd1) : (t_q == 5'd9);

    if (cfg_we_i) needed_d = cfg_wdata_i;

    // Assembly write stage fills the block words
    if (p_valid_q) begin
      w_d[p_pos_q[5:2]] = w_q[p_pos_q[5:2]];
      case (p_pos_q[1:0])
        2'd0:    w_d[p_pos_q[5:2]][31:24] = p_pool_q ? rd_q : p_byte_q;
        2'd1:    w_d[p_pos_q[5:2]][23:16] = p_pool_q ? rd_q : p_byte_q;
        2'd2:    w_d[p_pos_q[5:2]][15:8]  = p_pool_q ? rd_q : p_byte_q;
        default: w_d[p_pos_q[5:2]][7:0]   = p_pool_q ? rd_q : p_byte_q;
      endcase
    end

    unique case (state_q)
      // Sweep zeros through the pool
      S_CLEAR: begin
        mem_we = 1'b1; mem_wa = clr_q; mem_wd = '0;
        clr_d  = clr_q + 1'b1;
        if (clr_q == AW'(TOTAL - 1)) begin
          clr_d = '0;
          if (dpend_q) begin
            dpend_d = 1'b0; dcnt_d = DW'(NDOTS); state_d = S_DOTS;
          end else begin
            state_d = S_IDLE;
          end
        end
      end

      S_IDLE: begin
        if (in_fire) begin
          case (item.operation)
            OP_RESET: begin
              cv_d = '0; lc_d = '0; rc_d = '0; cc_d = '0; pidx_d = '0;
              filled_d = '0; est_d = '0; fill_d = '0; clen_d = '0;
              dpend_d = 1'b1; state_d = S_CLEAR;
            end
            OP_ADD, OP_SEED: begin
              if (clen_q == 16'd0) lc_d = cv_q;
              cbuf_we = 1'b1;
              fill_d  = fill_inc;
              clen_d  = cl_inc;
              if (item.operation == OP_SEED)
                credit_d = (cl_inc >= 16'd512) ? EstMax : 13'({cl_inc[8:0], 4'd0});
              else
                credit_d = {1'b0, item.entropy_credit};
              last_d = item.last;
              if (item.last) clen_d = '0;
              if (fill_inc == 5'd20 || item.last) begin
                fill_d = '0; kind_d = MK_CHUNK; j_d = fill_inc; dots_d = 1'b0;
                st_d = pidx_q;
                idx_d = NW'(pidx_q) + NW'(fill_inc);
                mnum_d = NW'(pidx_q) + NW'(fill_inc);
                mden_d = PIW'(POOL_BYTES); rem_d = '0; mbit_d = '0;
                state_d = S_MOD;
              end
            end
            OP_READ: begin
              if (item.read_count != 7'd0) begin
                ok_d = ok_now;
                if (!ok_now)
                  est_d = (est_q > 13'(num16)) ? est_q - 13'(num16) : 13'd0;
                m_d = (filled_q != '0) ? filled_q : PIW'(POOL_BYTES);
                st_d = pidx_q; lmd_d = cv_q; left_d = numc; kind_d = MK_GROUP;
                idx_d  = NW'(pidx_q) + NW'(c10);
                mnum_d = NW'(pidx_q) + NW'(c10);
                mden_d = (filled_q != '0) ? filled_q : PIW'(POOL_BYTES);
                rem_d = '0; mbit_d = '0;
                state_d = S_MOD;
              end
            end
            OP_STATUS: state_d = S_STAT;
            default: ;
          endcase
        end
      end

      S_STAT: begin
        if (out_free) begin
          out_valid_d = 1'b1;
          out_d = '{random_byte: 8'd0, last_byte: 1'b1, seeded: ok_now};
          state_d = S_IDLE;
        end
      end

      // Start one call of twenty dots
      S_DOTS: begin
        lc_d = cv_q; dcnt_d = dcnt_q - 1'b1;
        kind_d = MK_CHUNK; j_d = 5'd20; dots_d = 1'b1; last_d = 1'b0;
        st_d = pidx_q;
        idx_d = NW'(pidx_q) + NW'(5'd20);
        mnum_d = NW'(pidx_q) + NW'(5'd20);
        mden_d = PIW'(POOL_BYTES); rem_d = '0; mbit_d = '0;
        state_d = S_MOD;
      end

      // Restoring remainder, one bit a cycle, then new pool index
      S_MOD: begin
        rem_d = (rem_sh >= (PIW+1)'(mden_q)) ? rem_sh - (PIW+1)'(mden_q) : rem_sh;
        mnum_d = mnum_q << 1;
        mbit_d = mbit_q + 1'b1;
        if (mbit_q == MBW'(NW - 1)) begin
          if (kind_q == MK_CHUNK) begin
            if (idx_q >= POOL_N) begin
              pidx_d = PIW'(rem_d); filled_d = PIW'(POOL_BYTES);
            end else begin
              pidx_d = PIW'(idx_q);
              if ((PIW+1)'(filled_q) < POOL_P && idx_q > NW'(filled_q))
                filled_d = PIW'(idx_q);
            end
          end else begin
            pidx_d = (idx_q > NW'(m_q)) ? PIW'(rem_d) : PIW'(idx_q);
          end
          h_d = SHA_IV; blk_d = 1'b0; lcnt_d = '0;
          state_d = S_LOAD;
        end
      end

      // Stream 64 message bytes into the block words
      S_LOAD: begin
        if (lcnt_q < 7'd64) begin
          mem_re = s0_pool;
          p_valid_d = 1'b1;
          lcnt_d = lcnt_q + 7'd1;
        end else begin
          a_d = h_q[159:128]; b_d = h_q[127:96]; c_d = h_q[95:64];
          d_d = h_q[63:32];   e_d = h_q[31:0];
          rnd_d = '0;
          state_d = S_ROUND;
        end
      end

      S_ROUND: begin
        e_d = d_q; d_d = c_q; c_d = {b_q[1:0], b_q[31:2]}; b_d = a_q; a_d = tmp;
        for (int i = 0; i < 15; i++) w_d[i] = w_q[i+1];
        w_d[15] = wnew;
        rnd_d = rnd_q + 7'd1;
        if (rnd_q == 7'd79) state_d = S_FIN;
      end

      // Chain add; next block or store the digest
      S_FIN: begin
        h_d = dig;
        if (blk_q != last_blk) begin
          blk_d = 1'b1; lcnt_d = '0; state_d = S_LOAD;
        end else begin
          t_d = '0;
          case (kind_q)
            MK_CHUNK: begin lc_d = dig;  state_d = S_XRD; end
            MK_GROUP: begin lmd_d = dig; state_d = S_XRD; end
            default: begin
              cv_d = dig; rc_d = rc_q + 32'd1; state_d = S_IDLE;
            end
          endcase
        end
      end

      // Fold the digest into the pool: read a pool byte, then write it back XORed
      S_XRD: begin
        mem_re = 1'b1;
        mem_ra = ((AW+1)'(st_q) >= TOTAL_W) ? '0 : AW'(st_q);
        wa_d   = mem_ra;
        state_d = S_XWR;
      end

      S_XWR: begin
        if (kind_q == MK_CHUNK || 4'(t_q) >= jg || out_free) begin
          mem_we = 1'b1; mem_wa = wa_q; mem_wd = rd_q ^ xbyte;
          st_d = (st_nx >= (AW+1)'(lim)) ? '0 : PIW'(st_nx);
          t_d = t_q + 5'd1;
          state_d = S_XRD;
          if (kind_q == MK_GROUP && 4'(t_q) < jg) begin
            out_valid_d = 1'b1;
            out_d = '{random_byte: dig_byte(lmd_q, t_q + 5'd10),
                      last_byte: (left_q <= 7'd10) && (4'(t_q) == jg - 4'd1),
                      seeded: ok_q};
          end
          if (xdone) begin
            if (kind_q == MK_CHUNK) begin
              cc_d = cc_q + 32'd1;
              state_d = S_POST;
            end else begin
              left_d = left_q - 7'(jg);
              kind_d = (left_q == 7'(jg)) ? MK_FINAL : MK_GROUP;
              h_d = SHA_IV; blk_d = 1'b0; lcnt_d = '0;
              state_d = S_LOAD;
            end
          end
        end
      end

      // Close an add, seed or dots call
      S_POST: begin
        state_d = S_IDLE;
        if (dots_q) begin
          cv_d = cv_q ^ lc_q;
          if (dcnt_q != '0) state_d = S_DOTS;
        end else if (last_q) begin
          cv_d = cv_q ^ lc_q;
          if (!ok_now) est_d = (est_sum > 14'(EstMax)) ? EstMax : est_sum[12:0];
        end
      end

      default: state_d = S_IDLE;
    endcase
  end

  // State registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_CLEAR;  kind_q <= MK_CHUNK;  needed_q <= EntropyNeededReset;
      pidx_q <= '0; filled_q <= '0; est_q <= '0; rc_q <= '0; cc_q <= '0;
      cv_q <= '0; lc_q <= '0; clen_q <= '0; fill_q <= '0;
      lcnt_q <= '0; rnd_q <= '0; t_q <= '0; mbit_q <= '0; blk_q <= 1'b0;
      dots_q <= 1'b0; dpend_q <= 1'b0; dcnt_q <= '0; last_q <= 1'b0;
      clr_q <= '0; p_valid_q <= 1'b0; out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;  kind_q <= kind_d;  needed_q <= needed_d;
      pidx_q <= pidx_d; filled_q <= filled_d; est_q <= est_d; rc_q <= rc_d; cc_q <= cc_d;
      cv_q <= cv_d; lc_q <= lc_d; clen_q <= clen_d; fill_q <= fill_d;
      lcnt_q <= lcnt_d; rnd_q <= rnd_d; t_q <= t_d; mbit_q <= mbit_d; blk_q <= blk_d;
      dots_q <= dots_d; dpend_q <= dpend_d; dcnt_q <= dcnt_d; last_q <= last_d;
      clr_q <= clr_d; p_valid_q <= p_valid_d; out_valid_q <= out_valid_d;
    end
  end

  // Datapath registers
  always_ff @(posedge clk_i) begin
    st_q <= st_d; m_q <= m_d; mden_q <= mden_d; credit_q <= credit_d;
    lmd_q <= lmd_d; j_q <= j_d; left_q <= left_d; ok_q <= ok_d;
    idx_q <= idx_d; mnum_q <= mnum_d; rem_q <= rem_d; h_q <= h_d; wa_q <= wa_d;
    a_q <= a_d; b_q <= b_d; c_q <= c_d; d_q <= d_d; e_q <= e_d;
    w_q <= w_d;
    p_pool_q <= p_pool_d; p_pos_q <= p_pos_d; p_byte_q <= p_byte_d;
    out_q <= out_d;
  end

  // Checks
  a_pidx_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (PIW+1)'(pidx_q) <= POOL_P)
    else $error("pool index beyond pool size");

  a_round_end: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_ROUND && rnd_q == 7'd79) |=> (state_q == S_FIN))
    else $error("round count did not end compression");

  a_fill_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_IDLE) |-> (fill_q < 5'd20))
    else $error("chunk buffer full while idle");

endmodule
